### hdl/idll_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the indexed doubly linked list block.
// No dependencies; every other file of the block but idll_ram imports this package.
package idll_pkg;

    // Width of a node number on the ports and in the link memories
    localparam int NODE_W        = 10;
    // Default node count (memory depth)
    localparam int NODES_DEFAULT = 1024;
    // Stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W     = 24;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 24;
    localparam int M_TUSER_W     = 1;

    typedef enum logic [1:0] {
        OP_INS_RIGHT = 2'd0,
        OP_INS_LEFT  = 2'd1,
        OP_DELETE    = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    // Class of a request as decided by the front part
    typedef enum logic [2:0] {
        CLS_ZERO,    // out of range: all-zero result, no access
        CLS_REPORT,  // report the anchor's links only
        CLS_INS_R,   // insert right of anchor
        CLS_INS_L,   // insert left of anchor
        CLS_DEL      // delete anchor
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [NODE_W-1:0] anchor;
        logic [NODE_W-1:0] new_node;
    } cmd_t;

    function automatic logic node_in_range(input logic [NODE_W-1:0] node, input int nodes);
        return (32'(node) < 32'(nodes));
    endfunction

endpackage

### hdl/indexed_doubly_linked_list_top.sv
`timescale 1ns / 1ps
// Top level of the indexed doubly linked list block.
// Depends on idll_pkg, idll_front, idll_back (and through it idll_ram).

// The block keeps a doubly linked list of node numbers with node 0 as head
// sentinel; after reset the list holds node 1 alone. Each request on the
// slave stream inserts new_node right or left of an anchor, deletes the
// anchor, or queries it, and returns one result: the anchor's successor and
// predecessor after the operation, with a status flag set when a delete hits
// a node already marked deleted. Out-of-range nodes give an all-zero result.
// After reset a clearing pass writes the link and mark memories, one entry a
// cycle; s_tready stays low until it ends. Requests then enter a two-entry
// queue and a sequencer carries them out against three memories with one
// write and one registered read port each: it reads the anchor's links, an
// insert left first steps to the anchor's predecessor, inserts and deletes
// read then write the links over those ports, and the anchor's links are
// read back for the result. The result sits in an output register, so the
// queue keeps taking requests while it waits.
module indexed_doubly_linked_list_top #(
    parameter int NODES = idll_pkg::NODES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [idll_pkg::S_TDATA_W-1:0] s_tdata,  // anchor[9:0], new_node[19:10], zero pad
    input  logic [idll_pkg::S_TUSER_W-1:0] s_tuser,  // op[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [idll_pkg::M_TDATA_W-1:0] m_tdata,  // succ_node[9:0], pred_node[19:10], zero pad
    output logic [idll_pkg::M_TUSER_W-1:0] m_tuser   // status[0]
);
    import idll_pkg::*;

    logic              init_done;
    logic              cmd_valid;
    cmd_t              cmd;
    logic              cmd_pop;
    logic              res_status;
    logic [NODE_W-1:0] res_succ;
    logic [NODE_W-1:0] res_pred;

    // Classify requests and hold them until the sequencer is free
    idll_front #(.NODES(NODES)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enable     (init_done),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_op       (s_tuser[1:0]),
        .s_anchor   (s_tdata[NODE_W-1:0]),
        .s_new_node (s_tdata[2*NODE_W-1:NODE_W]),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // Walk the link memories and drive the result register
    idll_back #(.NODES(NODES)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_status  (res_status),
        .m_succ    (res_succ),
        .m_pred    (res_pred)
    );

    // Pack the result, padding the upper bits with zeros
    assign m_tdata = {(M_TDATA_W - 2*NODE_W)'(0), res_pred, res_succ};
    assign m_tuser = res_status;

endmodule

### hdl/idll_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module idll_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/idll_front.sv
`timescale 1ns / 1ps
// Front part: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on idll_pkg.
module idll_front #(
    parameter int NODES = idll_pkg::NODES_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      enable,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [idll_pkg::NODE_W-1:0] s_anchor,
    input  logic [idll_pkg::NODE_W-1:0] s_new_node,
    output logic                      cmd_valid,
    output idll_pkg::cmd_t            cmd,
    input  logic                      cmd_pop
);
    import idll_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls_cmd;
    op_t        op;
    logic       push;
    logic       pop;

    assign op = op_t'(s_op);

    // Classify the request
    always_comb begin
        cls_cmd.anchor   = s_anchor;
        cls_cmd.new_node = s_new_node;
        priority if (!node_in_range(s_anchor, NODES)) begin
            cls_cmd.cls = CLS_ZERO;
        end else if ((op == OP_INS_RIGHT || op == OP_INS_LEFT) && s_new_node != '0) begin
            if (!node_in_range(s_new_node, NODES)) begin
                cls_cmd.cls = CLS_ZERO;
            end else if (op == OP_INS_RIGHT) begin
                cls_cmd.cls = CLS_INS_R;
            end else begin
                cls_cmd.cls = CLS_INS_L;
            end
        end else if (op == OP_DELETE && s_anchor != '0) begin
            cls_cmd.cls = CLS_DEL;
        end else begin
            cls_cmd.cls = CLS_REPORT;
        end
    end

    assign s_ready   = enable && (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

### hdl/idll_back.sv
`timescale 1ns / 1ps
// Back part: sequencer over the successor, predecessor and deleted-mark memories,
// with the post-reset clearing pass and the result register. Depends on idll_pkg, idll_ram.
module idll_back #(
    parameter int NODES = idll_pkg::NODES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    output logic                        init_done,
    input  logic                        cmd_valid,
    input  idll_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [idll_pkg::NODE_W-1:0] m_succ,
    output logic [idll_pkg::NODE_W-1:0] m_pred
);
    import idll_pkg::*;

    localparam int AW = $clog2(NODES);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_INS_AT,
        S_INS_W1,
        S_INS_W2,
        S_DEL_CHK,
        S_RD,
        S_RESULT,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     init_idx_reg, init_idx_next;
    cmd_t              cmd_reg, cmd_next;
    logic [NODE_W-1:0] at_reg, at_next;
    logic              res_status_reg, res_status_next;
    logic [NODE_W-1:0] res_succ_reg, res_succ_next;
    logic [NODE_W-1:0] res_pred_reg, res_pred_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [NODE_W-1:0] out_succ_reg, out_succ_next;
    logic [NODE_W-1:0] out_pred_reg, out_pred_next;

    logic              nx_we, pv_we, dm_we;
    logic [AW-1:0]     nx_waddr, pv_waddr, dm_waddr;
    logic [NODE_W-1:0] nx_wdata, pv_wdata;
    logic              dm_wdata;
    logic [AW-1:0]     nx_raddr, pv_raddr, dm_raddr;
    logic [NODE_W-1:0] nx_rdata, pv_rdata;
    logic              dm_rdata;

    function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] node);
        return AW'(node);
    endfunction

    idll_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next_ram (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );

    idll_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prev_ram (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(pv_raddr), .rdata(pv_rdata)
    );

    idll_ram #(.WIDTH(1), .DEPTH(NODES)) u_mark_ram (
        .aclk(aclk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        init_idx_next   = init_idx_reg;
        cmd_next        = cmd_reg;
        at_next         = at_reg;
        res_status_next = res_status_reg;
        res_succ_next   = res_succ_reg;
        res_pred_next   = res_pred_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_succ_next   = out_succ_reg;
        out_pred_next   = out_pred_reg;
        cmd_pop         = 1'b0;
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
        dm_we = 1'b0; dm_waddr = '0; dm_wdata = 1'b0;
        nx_raddr = to_addr(cmd_reg.anchor);
        pv_raddr = to_addr(cmd_reg.anchor);
        dm_raddr = to_addr(cmd_reg.anchor);

        unique case (state_reg)
            S_INIT: begin
                // Head points to node 1, everything else ends the list
                nx_we    = 1'b1;
                nx_waddr = init_idx_reg;
                nx_wdata = (init_idx_reg == '0) ? NODE_W'(1) : '0;
                pv_we    = (init_idx_reg == AW'(1));
                pv_waddr = init_idx_reg;
                dm_we    = 1'b1;
                dm_waddr = init_idx_reg;
                init_idx_next = init_idx_reg + AW'(1);
                if (init_idx_reg == AW'(NODES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    at_next  = cmd.anchor;
                    nx_raddr = to_addr(cmd.anchor);
                    pv_raddr = to_addr(cmd.anchor);
                    dm_raddr = to_addr(cmd.anchor);
                    unique case (cmd.cls)
                        CLS_ZERO: begin
                            res_status_next = STATUS_DONE;
                            res_succ_next   = '0;
                            res_pred_next   = '0;
                            state_next      = S_DONE;
                        end
                        CLS_REPORT: state_next = S_RESULT;
                        CLS_INS_R:  state_next = S_INS_W1;
                        CLS_INS_L:  state_next = S_INS_AT;
                        CLS_DEL:    state_next = S_DEL_CHK;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_AT: begin
                // Predecessor becomes the insertion point
                if (!node_in_range(pv_rdata, NODES)) begin
                    res_status_next = STATUS_DONE;
                    res_succ_next   = '0;
                    res_pred_next   = '0;
                    state_next      = S_DONE;
                end else begin
                    at_next    = pv_rdata;
                    nx_raddr   = to_addr(pv_rdata);
                    state_next = S_INS_W1;
                end
            end
            S_INS_W1: begin
                if (!node_in_range(nx_rdata, NODES)) begin
                    res_status_next = STATUS_DONE;
                    res_succ_next   = '0;
                    res_pred_next   = '0;
                    state_next      = S_DONE;
                end else begin
                    nx_we      = 1'b1;
                    nx_waddr   = to_addr(cmd_reg.new_node);
                    nx_wdata   = nx_rdata;
                    pv_we      = 1'b1;
                    pv_waddr   = to_addr(nx_rdata);
                    pv_wdata   = cmd_reg.new_node;
                    state_next = S_INS_W2;
                end
            end
            S_INS_W2: begin
                nx_we      = 1'b1;
                nx_waddr   = to_addr(at_reg);
                nx_wdata   = cmd_reg.new_node;
                pv_we      = 1'b1;
                pv_waddr   = to_addr(cmd_reg.new_node);
                pv_wdata   = at_reg;
                state_next = S_RD;
            end
            S_DEL_CHK: begin
                priority if (dm_rdata) begin
                    res_status_next = STATUS_IGNORED;
                    res_succ_next   = nx_rdata;
                    res_pred_next   = pv_rdata;
                    state_next      = S_DONE;
                end else if (!node_in_range(pv_rdata, NODES) ||
                             !node_in_range(nx_rdata, NODES)) begin
                    res_status_next = STATUS_DONE;
                    res_succ_next   = '0;
                    res_pred_next   = '0;
                    state_next      = S_DONE;
                end else begin
                    nx_we      = 1'b1;
                    nx_waddr   = to_addr(pv_rdata);
                    nx_wdata   = nx_rdata;
                    pv_we      = 1'b1;
                    pv_waddr   = to_addr(nx_rdata);
                    pv_wdata   = pv_rdata;
                    dm_we      = 1'b1;
                    dm_waddr   = to_addr(cmd_reg.anchor);
                    dm_wdata   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                res_status_next = STATUS_DONE;
                res_succ_next   = nx_rdata;
                res_pred_next   = pv_rdata;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_succ_next   = res_succ_reg;
                    out_pred_next   = res_pred_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg        <= cmd_next;
        at_reg         <= at_next;
        res_status_reg <= res_status_next;
        res_succ_reg   <= res_succ_next;
        res_pred_reg   <= res_pred_next;
        out_status_reg <= out_status_next;
        out_succ_reg   <= out_succ_next;
        out_pred_reg   <= out_pred_next;
    end

    assign init_done = (state_reg != S_INIT);
    assign m_valid   = out_valid_reg;
    assign m_status  = out_status_reg;
    assign m_succ    = out_succ_reg;
    assign m_pred    = out_pred_reg;

endmodule

### hdl/idll_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the indexed doubly linked list block, bound to the top level.
// Depends on idll_pkg and indexed_doubly_linked_list_top.
module idll_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [idll_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [idll_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [idll_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [idll_pkg::M_TUSER_W-1:0] m_tuser
);
    import idll_pkg::*;

    // Requests taken but whose result is not yet delivered
    logic [2:0] pending_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_reg + 3'(s_fire) - 3'(m_fire);
        end
    end

    // Reset starts the clearing pass: no request taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or valid high right after reset");

    // A result only ever answers a request already taken
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 3'd0)
        else $error("result without a pending request");

    // Queue, sequencer and output register hold at most four requests
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd4)
        else $error("more requests in flight than the block can hold");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind indexed_doubly_linked_list_top idll_checker u_idll_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/idll_link_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the indexed doubly linked list block: keeps its own copy of the
// successor, predecessor and deleted-mark memories and checks every result.
// Depends on idll_pkg.
module idll_link_checker #(
    parameter int NODES = idll_pkg::NODES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [idll_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [idll_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [idll_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [idll_pkg::M_TUSER_W-1:0] m_tuser,
    output int                             mismatches,
    output int                             open_requests,
    output int                             results_checked
);
    import idll_pkg::*;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        logic  status;
        node_t succ;
        node_t pred;
    } links_t;

    node_t  succ_mem [NODES];
    node_t  pred_mem [NODES];
    logic   dead_mem [NODES];
    links_t expected_links_q [$];
    int     err_total  = 0;
    int     seen_total = 0;

    function automatic logic fits(node_t n);
        return int'(n) < NODES;
    endfunction

    // Apply one request to the shadow memories and return the anchor's links.
    function automatic links_t apply_list_request(op_t op, node_t anchor, node_t new_node);
        links_t res;
        node_t  at;
        node_t  left_n;
        node_t  right_n;
        logic   ok;
        res = '0;
        ok  = fits(anchor);
        if (ok && (op == OP_INS_RIGHT || op == OP_INS_LEFT) && new_node != '0) begin
            at = (op == OP_INS_RIGHT) ? anchor : pred_mem[anchor];
            if (!fits(new_node) || !fits(at) || !fits(succ_mem[at])) begin
                ok = 1'b0;
            end else begin
                right_n            = succ_mem[at];
                succ_mem[new_node] = right_n;
                pred_mem[right_n]  = new_node;
                succ_mem[at]       = new_node;
                pred_mem[new_node] = at;
            end
        end else if (ok && op == OP_DELETE && anchor != '0) begin
            if (dead_mem[anchor]) begin
                res.status = STATUS_IGNORED;
            end else begin
                left_n  = pred_mem[anchor];
                right_n = succ_mem[anchor];
                if (!fits(left_n) || !fits(right_n)) begin
                    ok = 1'b0;
                end else begin
                    succ_mem[left_n]  = right_n;
                    pred_mem[right_n] = left_n;
                    dead_mem[anchor]  = 1'b1;
                end
            end
        end
        if (ok) begin
            res.succ = succ_mem[anchor];
            res.pred = pred_mem[anchor];
        end else begin
            res = '0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin : scoreboard
        links_t want;
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                succ_mem[i] = '0;
                pred_mem[i] = '0;
                dead_mem[i] = 1'b0;
            end
            succ_mem[0] = node_t'(1);
            expected_links_q.delete();
        end else begin
            // retire first: a result can never belong to a request taken at this edge
            if (m_tvalid && m_tready) begin
                seen_total++;
                if (expected_links_q.size() == 0) begin
                    $error("unexpected result: succ_node %0d, pred_node %0d, status %0d",
                           m_tdata[NODE_W-1:0], m_tdata[2*NODE_W-1:NODE_W], m_tuser[0]);
                    err_total++;
                end else begin
                    want = expected_links_q.pop_front();
                    if (m_tuser[0] !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tuser[0]);
                        err_total++;
                    end
                    if (m_tdata[NODE_W-1:0] !== want.succ) begin
                        $error("succ_node mismatch: expected %0d, actual %0d",
                               want.succ, m_tdata[NODE_W-1:0]);
                        err_total++;
                    end
                    if (m_tdata[2*NODE_W-1:NODE_W] !== want.pred) begin
                        $error("pred_node mismatch: expected %0d, actual %0d",
                               want.pred, m_tdata[2*NODE_W-1:NODE_W]);
                        err_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_links_q.push_back(apply_list_request(op_t'(s_tuser[1:0]),
                                                              s_tdata[NODE_W-1:0],
                                                              s_tdata[2*NODE_W-1:NODE_W]));
            end
        end
        mismatches      <= err_total;
        open_requests   <= expected_links_q.size();
        results_checked <= seen_total;
    end

endmodule

### bench/indexed_doubly_linked_list_top_test.sv
`timescale 1ns / 1ps
// Top of the bench for the indexed doubly linked list block: clock, reset,
// request stimulus, result-side backpressure, watchdog and verdict.
// Depends on idll_pkg, indexed_doubly_linked_list_top and idll_link_checker.
module indexed_doubly_linked_list_top_test;
    import idll_pkg::*;

    typedef logic [NODE_W-1:0] node_t;

    localparam int NODES        = NODES_DEFAULT;
    // The limit has to outlast the clearing pass after reset, which holds s_tready
    // low, and a single request plus random gaps and stalls.
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 210;

    // Pacing per phase: none, sender gaps, receiver stalls, both lightly
    int phase_idle  [4] = '{0, 61, 0, 9};
    int phase_stall [4] = '{0, 0, 61, 9};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // anchor[9:0], new_node[19:10], zero pad
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // op[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // succ_node[9:0], pred_node[19:10], zero pad
    logic [M_TUSER_W-1:0] m_tuser;         // status[0]

    int mismatches;
    int open_requests;
    int results_checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int requests_sent  = 0;
    int idle_cycles    = 0;

    // Nodes whose predecessor entry holds a written value. Only these may be
    // used as anchors: every result reads the anchor's predecessor.
    bit    prev_known [NODES];
    // Nodes deleted at least once; well-formed inserts and deletes avoid them
    bit    gone       [NODES];
    node_t known_q    [$];

    indexed_doubly_linked_list_top #(
        .NODES(NODES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    idll_link_checker #(
        .NODES(NODES)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .open_requests   (open_requests),
        .results_checked (results_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: stall at random at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic note_prev(node_t n);
        if (!prev_known[n]) begin
            prev_known[n] = 1'b1;
            known_q.push_back(n);
        end
    endtask

    // Present one request, holding it until the block takes it. Random sender
    // gaps come first so that they fall between any two requests.
    task automatic send_request(op_t op, node_t anchor, node_t new_node);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - 2 * NODE_W){1'b0}}, new_node, anchor};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        // a taken insert always writes the new node's predecessor
        if ((op == OP_INS_RIGHT || op == OP_INS_LEFT) && new_node != '0) begin
            note_prev(new_node);
        end
        if (op == OP_DELETE && anchor != '0) begin
            gone[anchor] = 1'b1;
        end
    endtask

    // Drop valid and hold off until every outstanding result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (open_requests != 0);
    endtask

    function automatic node_t pick_anchor(bit want_live);
        node_t n;
        n = known_q[0];
        for (int k = 0; k < 8; k++) begin
            n = known_q[$urandom_range(known_q.size() - 1)];
            if (!want_live || !gone[n]) return n;
        end
        return n;
    endfunction

    // Prefer a node never linked before so that the list stays well formed
    function automatic node_t pick_fresh();
        node_t n;
        n = node_t'(1);
        for (int k = 0; k < 16; k++) begin
            n = node_t'($urandom_range(NODES - 1, 1));
            if (!prev_known[n]) return n;
        end
        return n;
    endfunction

    // Mostly well-formed list edits with random content; the rest is noise:
    // any op on any usable anchor, re-inserts of linked nodes, node 0 inserts.
    task automatic send_random();
        int    roll;
        op_t   op;
        node_t anchor;
        node_t new_node;
        roll     = $urandom_range(99);
        new_node = node_t'($urandom_range(NODES - 1));
        if (roll < 85) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
                op       = OP_INS_RIGHT;
                anchor   = pick_anchor(1'b1);
                new_node = pick_fresh();
            end else if (roll < 50) begin
                op       = OP_INS_LEFT;
                anchor   = pick_anchor(1'b1);
                new_node = pick_fresh();
            end else if (roll < 75) begin
                op     = OP_DELETE;
                anchor = pick_anchor(1'b1);
            end else begin
                op     = OP_QUERY;
                anchor = pick_anchor(1'b0);
            end
        end else begin
            op     = op_t'($urandom_range(3));
            anchor = pick_anchor(1'b0);
            if ($urandom_range(9) == 0) new_node = '0;
        end
        send_request(op, anchor, new_node);
    endtask

    initial begin
        known_q.push_back(node_t'(1));
        prev_known[1] = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, no gaps or stalls. Append past the tail of the
        // initial list: this also writes the head's predecessor, so node 0
        // becomes a usable anchor from here on.
        send_request(OP_INS_RIGHT, 10'd1, 10'd2);
        note_prev('0);
        send_request(OP_QUERY,     10'd0, 10'd0);       // query the head
        send_request(OP_INS_LEFT,  10'd1, 10'd1023);    // insert left of the first node
        send_request(OP_QUERY,     10'd1023, 10'd1023);
        send_request(OP_INS_RIGHT, 10'd0, 10'd512);     // insert right of the head
        send_request(OP_INS_LEFT,  10'd0, 10'd3);       // left of head lands after the tail
        send_request(OP_INS_RIGHT, 10'd2, 10'd0);       // insert of node 0: ignored
        send_request(OP_INS_LEFT,  10'd1, 10'd0);
        send_request(OP_DELETE,    10'd0, 10'd682);     // delete of the head: ignored
        send_request(OP_DELETE,    10'd1023, 10'd341);
        send_request(OP_DELETE,    10'd1023, 10'd682);  // already deleted
        send_request(OP_QUERY,     10'd1023, 10'd0);    // deleted node keeps its links
        send_request(OP_DELETE,    10'd3, 10'd0);       // delete the tail
        send_request(OP_DELETE,    10'd512, 10'd0);     // delete the first node
        send_request(OP_INS_RIGHT, 10'd2, 10'd1023);    // re-link a deleted node
        send_request(OP_DELETE,    10'd1023, 10'd0);    // mark survives re-linking
        send_request(OP_INS_LEFT,  10'd2, 10'd1);       // insert a node already linked
        send_request(OP_QUERY,     10'd1, 10'd0);
        send_request(OP_QUERY,     10'd2, 10'd0);

        // Random part in four pacing phases; drain fully between phases so
        // the sender sits idle at least once with nothing outstanding.
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle_pct   = phase_idle[ph];
            recv_stall_pct <= phase_stall[ph];
            repeat (PHASE_ITEMS) send_random();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Drove %0d requests: directed inserts, deletes and queries, then random",
                 requests_sent);
        $display("edits under four pacing phases; %0d results compared, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
